// File: hdl/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
`default_nettype none
package psu_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int ROW_AW          = $clog2(MAX_ROW_BYTES);
  localparam int POS_W           = 14;
  localparam int BPP_W           = 4;
  localparam int HEIGHT_W        = 16;
  localparam int SLOT_W          = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_BYTES       = 2'd0,
    CFG_BYTES_PER_PIXEL = 2'd1,
    CFG_IMAGE_HEIGHT    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FILT_NONE    = 3'd0,
    FILT_SUB     = 3'd1,
    FILT_UP      = 3'd2,
    FILT_AVERAGE = 3'd3,
    FILT_PAETH   = 3'd4
  } filt_e;

  // One item handed from the position tracker to the reconstruction stage.
  typedef struct packed {
    logic              bad;
    logic [7:0]        data;
    logic [ROW_AW-1:0] addr;
    logic [SLOT_W-1:0] slot;
    logic              left_ok;
    logic              first_row;
    filt_e             filt;
    logic              row_end;
    logic              image_end;
  } req_t;

endpackage
`default_nettype wire

// File: hdl/png_scanline_unfilter.sv
// PNG scanline unfilter (None, Sub, Up, Average, Paeth) with a line store for the prior row.
//
// Input channel: in_valid_i / in_stall_o carry one inflated byte per item. Each
// row is a filter-type byte followed by row_bytes data bytes. The filter byte
// gives no result unless it is above 4, which gives one result with
// bad_filter_o set and drops the rest of that image.
// Output channel: out_valid_o / out_stall_i carry one reconstructed byte per
// data byte, with row_end_o and image_end_o flags.
// Config: cfg_valid_i / cfg_ready_o write row_bytes (index 0), bytes_per_pixel
// (index 1) and image_height (index 2); cfg_ready_o is always high.
// Throughput is one byte per cycle unless the output stalls: the line store is
// read at accept and the data arrives with the item in the reconstruction stage,
// where the predictor is combinational; the result then goes to the output register.
// A stalled output holds its result; the stage behind it takes one more item,
// then in_stall_o rises until the output drains.
// Reset clears position, row count, filter, history and drop state; the line
// store needs no clearing since the first row of an image ignores its read data.
`default_nettype none
module png_scanline_unfilter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [7:0]                      stream_byte_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [7:0]                      pixel_byte_o,
  output      logic                            row_end_o,
  output      logic                            image_end_o,
  output      logic                            bad_filter_o,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic                       accept;
  logic                       ready;
  logic                       req_valid;
  psu_pkg::req_t              req;
  logic                       rd_en;
  logic [psu_pkg::ROW_AW-1:0] rd_addr;
  logic [7:0]                 rd_data;
  logic                       wr_en;
  logic [psu_pkg::ROW_AW-1:0] wr_addr;
  logic [7:0]                 wr_data;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !ready;
  assign accept      = in_valid_i && ready;

  psu_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .stream_byte_i (stream_byte_i),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr)
  );

  psu_ram #(
    .WIDTH (8),
    .DEPTH (psu_pkg::MAX_ROW_BYTES)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  psu_recon u_recon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .ready_o      (ready),
    .up_rdata_i   (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_byte_o (pixel_byte_o),
    .row_end_o    (row_end_o),
    .image_end_o  (image_end_o),
    .bad_filter_o (bad_filter_o)
  );

endmodule
`default_nettype wire

// File: hdl/psu_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/psu_ctrl.sv
// Configuration registers and row/image position tracking; issues line store reads.
`default_nettype none
module psu_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            accept_i,
  input  wire logic [7:0]                      stream_byte_i,
  output      logic                            req_valid_o,
  output      psu_pkg::req_t                   req_o,
  output      logic                            rd_en_o,
  output      logic [psu_pkg::ROW_AW-1:0]      rd_addr_o
);

  localparam int AW = psu_pkg::ROW_AW;

  logic [psu_pkg::POS_W-1:0]    row_bytes_q;
  logic [psu_pkg::BPP_W-1:0]    bpp_q;
  logic [psu_pkg::HEIGHT_W-1:0] height_q;

  logic [psu_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [psu_pkg::HEIGHT_W-1:0] row_q, row_d;
  psu_pkg::filt_e               filt_q, filt_d;
  logic                         drop_q, drop_d;
  logic [1:0]                   m3_q, m3_d;
  logic [2:0]                   m5_q, m5_d;
  logic [2:0]                   m7_q, m7_d;

  logic [psu_pkg::POS_W-1:0]    rb_eff;
  logic [psu_pkg::BPP_W-1:0]    bpp_eff;
  logic [psu_pkg::HEIGHT_W-1:0] h_eff;
  logic [AW-1:0]                idx;
  logic                         row_done;
  logic                         last_row;
  logic [2:0]                   slot;
  logic [2:0]                   m6;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= psu_pkg::POS_W'(1);
      bpp_q       <= psu_pkg::BPP_W'(1);
      height_q    <= psu_pkg::HEIGHT_W'(1);
    end else if (cfg_we_i) begin
      case (psu_pkg::cfg_idx_e'(cfg_index_i))
        psu_pkg::CFG_ROW_BYTES:       row_bytes_q <= cfg_data_i[psu_pkg::POS_W-1:0];
        psu_pkg::CFG_BYTES_PER_PIXEL: bpp_q       <= cfg_data_i[psu_pkg::BPP_W-1:0];
        psu_pkg::CFG_IMAGE_HEIGHT:    height_q    <= cfg_data_i[psu_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_bytes_q == '0) begin
      rb_eff = psu_pkg::POS_W'(1);
    end else if (row_bytes_q > psu_pkg::POS_W'(psu_pkg::MAX_ROW_BYTES)) begin
      rb_eff = psu_pkg::POS_W'(psu_pkg::MAX_ROW_BYTES);
    end else begin
      rb_eff = row_bytes_q;
    end
    if (bpp_q == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (bpp_q > psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES)) begin
      bpp_eff = psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_q;
    end
    h_eff = (height_q == '0) ? psu_pkg::HEIGHT_W'(1) : height_q;
  end

  assign idx      = pos_q[AW-1:0] - AW'(1);
  assign row_done = pos_q >= rb_eff;
  assign last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};

  // Residue mod 6 from residues mod 3 and mod 2
  assign m6 = (m3_q[0] == idx[0]) ? {1'b0, m3_q} : ({1'b0, m3_q} + 3'd3);

  always_comb begin
    case (bpp_eff)
      4'd1:    slot = 3'd0;
      4'd2:    slot = {2'b0, idx[0]};
      4'd3:    slot = {1'b0, m3_q};
      4'd4:    slot = {1'b0, idx[1:0]};
      4'd5:    slot = m5_q;
      4'd6:    slot = m6;
      4'd7:    slot = m7_q;
      default: slot = idx[2:0];
    endcase
  end

  always_comb begin
    pos_d  = pos_q;
    row_d  = row_q;
    filt_d = filt_q;
    drop_d = drop_q;
    m3_d   = m3_q;
    m5_d   = m5_q;
    m7_d   = m7_q;

    req_valid_o     = 1'b0;
    req_o.bad       = 1'b0;
    req_o.data      = stream_byte_i;
    req_o.addr      = idx;
    req_o.slot      = slot;
    req_o.left_ok   = {{(AW-psu_pkg::BPP_W){1'b0}}, bpp_eff} <= idx;
    req_o.first_row = (row_done && last_row) ? (h_eff == psu_pkg::HEIGHT_W'(1))
                                             : (row_q == '0);
    req_o.filt      = filt_q;
    req_o.row_end   = row_done;
    req_o.image_end = row_done && last_row;

    if (accept_i) begin
      if (pos_q == '0) begin
        // Filter byte: restart the residue counters for a new row
        pos_d = psu_pkg::POS_W'(1);
        m3_d  = '0;
        m5_d  = '0;
        m7_d  = '0;
        if (!drop_q) begin
          if (stream_byte_i > {5'b0, psu_pkg::FILT_PAETH}) begin
            drop_d          = 1'b1;
            req_valid_o     = 1'b1;
            req_o.bad       = 1'b1;
            req_o.row_end   = 1'b0;
            req_o.image_end = 1'b0;
          end else begin
            filt_d = psu_pkg::filt_e'(stream_byte_i[2:0]);
          end
        end
      end else begin
        m3_d = (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
        m5_d = (m5_q == 3'd4) ? 3'd0 : m5_q + 3'd1;
        m7_d = (m7_q == 3'd6) ? 3'd0 : m7_q + 3'd1;
        if (row_done) begin
          pos_d = '0;
          row_d = last_row ? '0 : row_q + psu_pkg::HEIGHT_W'(1);
        end else begin
          pos_d = pos_q + psu_pkg::POS_W'(1);
        end
        if (drop_q) begin
          if (row_done && last_row) begin
            drop_d = 1'b0;
          end
        end else begin
          req_valid_o = 1'b1;
        end
      end
    end
  end

  assign rd_en_o   = req_valid_o && !req_o.bad;
  assign rd_addr_o = idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      row_q  <= '0;
      filt_q <= psu_pkg::FILT_NONE;
      drop_q <= 1'b0;
      m3_q   <= '0;
      m5_q   <= '0;
      m7_q   <= '0;
    end else begin
      pos_q  <= pos_d;
      row_q  <= row_d;
      filt_q <= filt_d;
      drop_q <= drop_d;
      m3_q   <= m3_d;
      m5_q   <= m5_d;
      m7_q   <= m7_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/psu_recon.sv
// Reconstruction stage: predictor, pixel history, line store write-back and output register.
`default_nettype none
module psu_recon (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic                        req_valid_i,
  input  wire psu_pkg::req_t               req_i,
  output      logic                        ready_o,
  input  wire logic [7:0]                  up_rdata_i,
  output      logic                        wr_en_o,
  output      logic [psu_pkg::ROW_AW-1:0]  wr_addr_o,
  output      logic [7:0]                  wr_data_o,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [7:0]                  pixel_byte_o,
  output      logic                        row_end_o,
  output      logic                        image_end_o,
  output      logic                        bad_filter_o
);

  logic          b_valid_q;
  psu_pkg::req_t b_q;
  logic          fwd_q;
  logic [7:0]    fwd_data_q;
  logic          b_adv;

  logic [7:0] left_hist_q   [psu_pkg::MAX_PIXEL_BYTES];
  logic [7:0] upleft_hist_q [psu_pkg::MAX_PIXEL_BYTES];

  logic       out_valid_q;
  logic [7:0] pixel_q;
  logic       row_end_q;
  logic       image_end_q;
  logic       bad_q;

  logic [7:0] up, left, upleft, pred, recon;
  logic [8:0] avg_sum;
  logic [7:0] pa, pb;
  logic [9:0] ab_sum, cc, pc;
  logic [7:0] paeth;

  assign b_adv   = b_valid_q && (!out_valid_q || !out_stall_i);
  assign ready_o = !b_valid_q || b_adv;

  always_comb begin
    up     = b_q.first_row ? 8'd0 : (fwd_q ? fwd_data_q : up_rdata_i);
    left   = b_q.left_ok ? left_hist_q[b_q.slot] : 8'd0;
    upleft = (b_q.left_ok && !b_q.first_row) ? upleft_hist_q[b_q.slot] : 8'd0;

    avg_sum = {1'b0, left} + {1'b0, up};

    pa     = (up >= upleft) ? up - upleft : upleft - up;
    pb     = (left >= upleft) ? left - upleft : upleft - left;
    ab_sum = {2'b0, left} + {2'b0, up};
    cc     = {1'b0, upleft, 1'b0};
    pc     = (ab_sum >= cc) ? ab_sum - cc : cc - ab_sum;
    if (pa <= pb && {2'b0, pa} <= pc) begin
      paeth = left;
    end else if ({2'b0, pb} <= pc) begin
      paeth = up;
    end else begin
      paeth = upleft;
    end

    case (b_q.filt)
      psu_pkg::FILT_SUB:     pred = left;
      psu_pkg::FILT_UP:      pred = up;
      psu_pkg::FILT_AVERAGE: pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH:   pred = paeth;
      default:               pred = 8'd0;
    endcase
    recon = b_q.data + pred;
  end

  assign wr_en_o   = b_adv && !b_q.bad;
  assign wr_addr_o = b_q.addr;
  assign wr_data_o = recon;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (accept_i && req_valid_i) begin
      b_valid_q <= 1'b1;
      // A read racing the write of the same entry returns stale data: forward
      fwd_q     <= wr_en_o && (wr_addr_o == req_i.addr);
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && req_valid_i) begin
      b_q <= req_i;
    end
    if (b_adv) begin
      fwd_data_q <= recon;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
        left_hist_q[k]   <= 8'd0;
        upleft_hist_q[k] <= 8'd0;
      end
    end else if (wr_en_o) begin
      left_hist_q[b_q.slot]   <= recon;
      upleft_hist_q[b_q.slot] <= up;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      pixel_q     <= b_q.bad ? 8'd0 : recon;
      row_end_q   <= b_q.row_end;
      image_end_q <= b_q.image_end;
      bad_q       <= b_q.bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_q;
  assign row_end_o    = row_end_q;
  assign image_end_o  = image_end_q;
  assign bad_filter_o = bad_q;

endmodule
`default_nettype wire

// File: test/png_scanline_unfilter_tb.sv
// Self-checking testbench for png_scanline_unfilter: random PNG scanline streams vs a predictor.
module png_scanline_unfilter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  FIRST_BAD_FILTER = 8'd5;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned RANDOM_ITEMS     = 1350;

  typedef struct {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
  } pixel_t;

  class unfilter_scoreboard;
    logic [15:0]    row_bytes_raw;
    logic [15:0]    bpp_raw;
    logic [15:0]    height_raw;
    logic [7:0]     line_store [psu_pkg::MAX_ROW_BYTES];
    logic [7:0]     left_hist [psu_pkg::MAX_PIXEL_BYTES];
    logic [7:0]     upleft_hist [psu_pkg::MAX_PIXEL_BYTES];
    int unsigned    pos;
    int unsigned    row;
    int unsigned    written_hi;
    psu_pkg::filt_e filt;
    bit             dropping;
    pixel_t         expected_pixels [$];
    int             errors;

    function new();
      row_bytes_raw = 16'd1;
      bpp_raw       = 16'd1;
      height_raw    = 16'd1;
      pos           = 0;
      row           = 0;
      written_hi    = 0;
      filt          = psu_pkg::FILT_NONE;
      dropping      = 1'b0;
      errors        = 0;
      foreach (left_hist[k]) begin
        left_hist[k]   = 8'd0;
        upleft_hist[k] = 8'd0;
      end
      foreach (line_store[k]) line_store[k] = 8'd0;
    endfunction

    function int unsigned row_len(logic [15:0] raw);
      int unsigned n;
      n = raw[psu_pkg::POS_W-1:0];
      if (n == 0) n = 1;
      if (n > psu_pkg::MAX_ROW_BYTES) n = psu_pkg::MAX_ROW_BYTES;
      return n;
    endfunction

    function bit at_image_start();
      return pos == 0 && row == 0;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void write_reg(psu_pkg::cfg_idx_e idx, logic [15:0] data);
      case (idx)
        psu_pkg::CFG_ROW_BYTES:       row_bytes_raw = data;
        psu_pkg::CFG_BYTES_PER_PIXEL: bpp_raw = data;
        psu_pkg::CFG_IMAGE_HEIGHT:    height_raw = data;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned rb, bpp, h, i, slot, row_before;
      int          pa, pb, pc;
      bit          row_done, last_row, first_row;
      logic [7:0]  left, up, upleft, pred, recon;
      pixel_t      e;
      rb  = row_len(row_bytes_raw);
      bpp = bpp_raw[psu_pkg::BPP_W-1:0];
      if (bpp == 0) bpp = 1;
      if (bpp > psu_pkg::MAX_PIXEL_BYTES) bpp = psu_pkg::MAX_PIXEL_BYTES;
      h = (height_raw == 0) ? 1 : height_raw;

      if (pos == 0) begin
        pos = 1;
        if (dropping) return;
        if (b > 8'(psu_pkg::FILT_PAETH)) begin
          dropping = 1'b1;
          e = '{pixel: 8'd0, row_end: 1'b0, image_end: 1'b0, bad_filter: 1'b1};
          expected_pixels.push_back(e);
          return;
        end
        filt = psu_pkg::filt_e'(b[2:0]);
        return;
      end

      i          = pos - 1;
      row_before = row;
      row_done   = (pos >= rb);
      last_row   = (row + 1 >= h);
      if (row_done) begin
        pos = 0;
        row = last_row ? 0 : row + 1;
      end else begin
        pos = pos + 1;
      end

      if (dropping) begin
        if (row_done && last_row) dropping = 1'b0;
        return;
      end

      // closing row of an image counts as the first only when the height is one
      first_row = (row_done && last_row) ? (h == 1) : (row_before == 0);
      slot   = i % bpp;
      up     = first_row ? 8'd0 : line_store[i];
      left   = (i >= bpp) ? left_hist[slot] : 8'd0;
      upleft = (i >= bpp && !first_row) ? upleft_hist[slot] : 8'd0;

      case (filt)
        psu_pkg::FILT_SUB:     pred = left;
        psu_pkg::FILT_UP:      pred = up;
        psu_pkg::FILT_AVERAGE: pred = 8'((int'(left) + int'(up)) >> 1);
        psu_pkg::FILT_PAETH: begin
          pa = int'(up) - int'(upleft);
          pb = int'(left) - int'(upleft);
          pc = int'(left) + int'(up) - 2 * int'(upleft);
          if (pa < 0) pa = -pa;
          if (pb < 0) pb = -pb;
          if (pc < 0) pc = -pc;
          if (pa <= pb && pa <= pc) pred = left;
          else if (pb <= pc)        pred = up;
          else                      pred = upleft;
        end
        default: pred = 8'd0;
      endcase
      recon = b + pred;

      left_hist[slot]   = recon;
      upleft_hist[slot] = up;
      line_store[i]     = recon;
      if (i + 1 > written_hi) written_hi = i + 1;

      e = '{pixel: recon, row_end: row_done, image_end: row_done && last_row, bad_filter: 1'b0};
      expected_pixels.push_back(e);
    endfunction

    function void check_pixel(logic [7:0] pix, logic re, logic ie, logic bf);
      pixel_t e;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected item pixel_byte=%h row_end=%b image_end=%b bad_filter=%b",
                 $time, pix, re, ie, bf);
        return;
      end
      e = expected_pixels.pop_front();
      if (pix !== e.pixel) begin
        errors++;
        $display("%0t: pixel_byte expected %h, got %h", $time, e.pixel, pix);
      end
      if (re !== e.row_end) begin
        errors++;
        $display("%0t: row_end expected %b, got %b", $time, e.row_end, re);
      end
      if (ie !== e.image_end) begin
        errors++;
        $display("%0t: image_end expected %b, got %b", $time, e.image_end, ie);
      end
      if (bf !== e.bad_filter) begin
        errors++;
        $display("%0t: bad_filter expected %b, got %b", $time, e.bad_filter, bf);
      end
    endfunction
  endclass

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic [7:0]                     stream_byte_i = 8'd0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic [7:0]                     pixel_byte_o;
  logic                           row_end_o;
  logic                           image_end_o;
  logic                           bad_filter_o;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  unfilter_scoreboard sb = new();
  bit                 calm_in  = 1'b0;
  bit                 calm_out = 1'b0;
  int unsigned        stall_left = 0;
  int unsigned        sent_items = 0;
  logic [7:0]         opening_bytes [26];

  png_scanline_unfilter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (stream_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_byte_o  (pixel_byte_o),
    .row_end_o     (row_end_o),
    .image_end_o   (image_end_o),
    .bad_filter_o  (bad_filter_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check each accepted result, then draw the stall before the next one.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_pixel(pixel_byte_o, row_end_o, image_end_o, bad_filter_o);
      stall_left = calm_out ? 0 : $urandom_range(0, 9);
      out_stall_i <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= (stall_left != 0);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_byte(b);
  endtask

  // Drop valid and wait until every expected item is out and the pipe is empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [2:0] mask, input logic [15:0] rows,
                            input logic [15:0] pixel_bytes, input logic [15:0] height);
    psu_pkg::cfg_idx_e regs [3];
    logic [15:0]       vals [3];
    regs[0] = psu_pkg::CFG_ROW_BYTES;
    regs[1] = psu_pkg::CFG_BYTES_PER_PIXEL;
    regs[2] = psu_pkg::CFG_IMAGE_HEIGHT;
    vals[0] = rows;
    vals[1] = pixel_bytes;
    vals[2] = height;
    for (int k = 0; k < 3; k++) begin
      if (mask[k]) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= regs[k];
        cfg_data_i  <= vals[k];
        do @(posedge clk_i); while (!cfg_ready_o);
        sb.write_reg(regs[k], vals[k]);
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Send rows: a filter byte at each row start (now and then an invalid one), random data otherwise.
  task automatic stream_rows(input int count, input bit to_boundary);
    int         n;
    logic [7:0] b;
    n = 0;
    while (n < count || (to_boundary && !sb.at_image_start())) begin
      if (sb.pos == 0)
        b = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(FIRST_BAD_FILTER, 255))
                                         : 8'($urandom_range(0, psu_pkg::FILT_PAETH));
      else if ($urandom_range(0, 7) == 0)
        b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      else
        b = 8'($urandom);
      sent_items++;
      send_byte(b);
      n++;
    end
  endtask

  initial begin
    int unsigned kind, phase;
    logic [2:0]  mask;
    logic [15:0] rb_raw, bpp_raw, h_raw;

    opening_bytes = '{8'(psu_pkg::FILT_PAETH), 8'hFF,
                      8'(psu_pkg::FILT_SUB), 8'h01, 8'hFF, 8'h80,
                      8'(psu_pkg::FILT_UP), 8'hFF, 8'h00, 8'h7F,
                      8'(psu_pkg::FILT_AVERAGE), 8'h80, 8'hFF, 8'h01,
                      8'(psu_pkg::FILT_NONE), 8'hFF, 8'h00, 8'h55,
                      8'(psu_pkg::FILT_PAETH), 8'h10, 8'hF0, 8'h00,
                      FIRST_BAD_FILTER, 8'h12, 8'h34, 8'h56};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First two items run on the reset configuration.
    foreach (opening_bytes[k]) begin
      if (k == 2) begin
        settle();
        write_regs(3'b111, 16'd3, 16'd1, 16'd3);
      end
      send_byte(opening_bytes[k]);
    end

    // Out-of-range writes clamp to the widest row and the largest pixel;
    // send part of that row and let the next phase cut it short.
    settle();
    calm_in  = ($urandom_range(0, 1) == 0);
    calm_out = ($urandom_range(0, 1) == 0);
    write_regs(3'b111, 16'hFFFF, 16'h000C, 16'd2);
    stream_rows($urandom_range(20, 60), 1'b0);

    sent_items = 0;
    phase      = 0;
    while (sent_items < RANDOM_ITEMS) begin
      kind     = (phase < 2) ? phase : $urandom_range(2, 9);
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      mask     = 3'b111;
      bpp_raw  = 16'($urandom_range(1, psu_pkg::MAX_PIXEL_BYTES));
      case (kind)
        0: begin
          // tallest image; a later phase cuts it short mid-image
          rb_raw = 16'($urandom_range(1, 3));
          h_raw  = 16'hFFFF;
        end
        1: begin
          case ($urandom_range(0, 2))
            0:       rb_raw = 16'h0000;
            1:       rb_raw = 16'h4000;
            default: rb_raw = 16'hC005;
          endcase
          case ($urandom_range(0, 3))
            0:       bpp_raw = 16'd0;
            1:       bpp_raw = 16'd9;
            2:       bpp_raw = 16'd15;
            default: bpp_raw = 16'hFFF2;
          endcase
          h_raw = 16'd0;
        end
        default: begin
          rb_raw = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(25, 200))
                                               : 16'($urandom_range(1, 24));
          h_raw  = 16'($urandom_range(1, 6));
          mask   = 3'($urandom_range(1, 7));
          if (sb.height_raw > 16) mask[2] = 1'b1;
          if (sb.row_len(sb.row_bytes_raw) > 200) mask[0] = 1'b1;
        end
      endcase
      // keep later rows of this image inside the part of the line store already filled
      if (sb.row != 0 && !sb.dropping && sb.row_len(rb_raw) > sb.written_hi)
        rb_raw = 16'($urandom_range(1, sb.written_hi));

      settle();
      write_regs(mask, rb_raw, bpp_raw, h_raw);
      if (kind == 0)
        stream_rows($urandom_range(40, 80), 1'b0);
      else if (kind <= 3)
        stream_rows($urandom_range(1, 60), 1'b0);
      else
        stream_rows($urandom_range(20, 150), 1'b1);
      phase++;
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** png_scanline_unfilter: PASSED **");
    else
      $display("** png_scanline_unfilter: FAILED **");
    $finish;
  end

  initial begin
    #(12_000_000);
    $display("%0t: timeout", $time);
    $display("** png_scanline_unfilter: FAILED **");
    $finish;
  end

endmodule
